/* hdl/checked_signed_arithmetic_unit_macros.svh */
// assertion macros for the checked signed arithmetic unit
// expects clk and rst_n in the scope of use
`ifndef CHECKED_SIGNED_ARITHMETIC_UNIT_MACROS_SVH
`define CHECKED_SIGNED_ARITHMETIC_UNIT_MACROS_SVH

// same-cycle implication
`define CSAU_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CSAU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/csau_pkg.sv */
// shared codes, widths and types of the checked signed arithmetic unit
// no dependencies
package csau_pkg;

    localparam int PORT_W = 64;

    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;
    localparam logic [2:0] OP_POW = 3'd4;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_OVF    = 2'd1;
    localparam logic [1:0] ST_DIV0   = 2'd2;
    localparam logic [1:0] ST_NEGEXP = 2'd3;

    typedef struct packed {
        logic shift;
        logic in_bit;
        logic sub;
    } alu_ctl_t;

endpackage

/* hdl/csau_req_if.sv */
// request channel: op code and two signed operands
// depends on csau_pkg
interface csau_req_if
    import csau_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic [2:0]               op;
    logic signed [PORT_W-1:0] operand_a;
    logic signed [PORT_W-1:0] operand_b;

    modport source (output valid, op, operand_a, operand_b, input ready);
    modport sink (input valid, op, operand_a, operand_b, output ready);
endinterface

/* hdl/csau_rsp_if.sv */
// response channel: signed result and status
// depends on csau_pkg
interface csau_rsp_if
    import csau_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic signed [PORT_W-1:0] value;
    logic [1:0]               status;

    modport source (output valid, value, status, input ready);
    modport sink (input valid, value, status, output ready);
endinterface

/* hdl/csau_alu.sv */
// shared shift-and-add/subtract unit used by every operation
// depends on csau_pkg
module csau_alu
    import csau_pkg::*;
#(
    parameter int DATA_WIDTH = 64
) (
    input  logic [DATA_WIDTH+1:0] x,
    input  logic [DATA_WIDTH+1:0] y,
    input  alu_ctl_t              ctl,
    output logic [DATA_WIDTH+1:0] sum
);
    localparam int L = DATA_WIDTH + 2;

    logic [L-1:0] xs;
    logic [L-1:0] ys;

    always_comb
    begin
        xs  = ctl.shift ? {x[L-2:0], ctl.in_bit} : x;
        ys  = ctl.sub ? ~y : y;
        sum = xs + ys + {{(L-1){1'b0}}, ctl.sub};
    end
endmodule

/* hdl/checked_signed_arithmetic_unit.sv */
// checked signed arithmetic unit: sequencer around one shared shift/add unit
// depends on csau_pkg, csau_req_if, csau_rsp_if, csau_alu, macros header
//
//   channel  | dir | payload                      | beat accepted
//   in_ch    | in  | op, operand_a, operand_b     | valid && ready
//   out_ch   | out | value, status                | valid && ready
//
// add/subtract go through the S_ADD state; multiply and divide take one
// bit per cycle through the shared adder; power: up to 2*clog2(DATA_WIDTH)
// multiplies, each run through S_POW and S_MUL.
// one request at a time; in_ch.ready is high only while idle.
// a finished result waits in the sequencer while the output register is full and out_ch.ready is low.
// rst_n clears the sequencer and output valid asynchronously.
`include "checked_signed_arithmetic_unit_macros.svh"

module checked_signed_arithmetic_unit
    import csau_pkg::*;
#(
    parameter int DATA_WIDTH = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    csau_req_if.sink   in_ch,
    csau_rsp_if.source out_ch
);
    localparam int W   = DATA_WIDTH;
    localparam int L   = W + 2;
    localparam int EBW = $clog2(W);
    localparam int IW  = $clog2(EBW);
    localparam int CW  = $clog2(W);

    typedef enum logic [2:0] {S_IDLE, S_ADD, S_MUL, S_DIV, S_POW, S_FIN} state_t;

    state_t         state_reg;
    logic [2:0]     op_reg;
    logic [W-1:0]   a_raw_reg;
    logic [W-1:0]   b_raw_reg;
    logic [W-1:0]   amag_reg;
    logic [W-1:0]   bmag_reg;
    logic           neg_reg;
    logic [W:0]     acc_reg;
    logic [W-1:0]   mcand_reg;
    logic [W-1:0]   mplier_reg;
    logic [CW-1:0]  cnt_reg;
    logic [IW-1:0]  idx_reg;
    logic           pow_mul_reg;
    logic [W-1:0]   m_reg;
    logic [W-1:0]   res_mag_reg;
    logic           res_neg_reg;
    logic [1:0]     res_st_reg;
    logic           out_valid_reg;
    logic [PORT_W-1:0] out_value_reg;
    logic [1:0]     out_status_reg;

    logic [W-1:0]   a_low;
    logic [W-1:0]   b_low;
    logic [W-1:0]   a_mag;
    logic [W-1:0]   b_mag;
    logic [L-1:0]   alu_x;
    logic [L-1:0]   alu_y;
    logic [L-1:0]   alu_sum;
    alu_ctl_t       alu_ctl;
    logic [L-1:0]   lim;
    logic [EBW-1:0] ebits;
    logic           qbit;
    logic [W-1:0]   q_new;
    logic [W-1:0]   fin_mag;
    logic signed [W-1:0] fin_s;
    logic           out_free;

    csau_alu #(.DATA_WIDTH(W)) u_alu (
        .x   (alu_x),
        .y   (alu_y),
        .ctl (alu_ctl),
        .sum (alu_sum)
    );

    always_comb
    begin
        a_low   = in_ch.operand_a[W-1:0];
        b_low   = in_ch.operand_b[W-1:0];
        a_mag   = a_low[W-1] ? ({W{1'b0}} - a_low) : a_low;
        b_mag   = b_low[W-1] ? ({W{1'b0}} - b_low) : b_low;
        lim     = {3'b000, {(W-1){1'b1}}} + {{(L-1){1'b0}}, neg_reg};
        ebits   = bmag_reg[EBW-1:0];
        alu_x   = {1'b0, acc_reg};
        alu_y   = {2'b00, bmag_reg};
        alu_ctl = '{shift: 1'b1, in_bit: 1'b0, sub: 1'b0};
        case (state_reg)
            S_ADD:
            begin
                alu_x   = {{2{a_raw_reg[W-1]}}, a_raw_reg};
                alu_y   = {{2{b_raw_reg[W-1]}}, b_raw_reg};
                alu_ctl = '{shift: 1'b0, in_bit: 1'b0, sub: (op_reg == OP_SUB)};
            end
            S_MUL:
            begin
                alu_y   = mplier_reg[W-1] ? {2'b00, mcand_reg} : {L{1'b0}};
            end
            S_DIV:
            begin
                alu_ctl = '{shift: 1'b1, in_bit: mplier_reg[W-1], sub: 1'b1};
            end
            default:
            begin
                alu_ctl = '{shift: 1'b1, in_bit: 1'b0, sub: 1'b0};
            end
        endcase
        qbit     = ~alu_sum[L-1];
        q_new    = {mplier_reg[W-2:0], qbit};
        fin_mag  = res_neg_reg ? ({W{1'b0}} - res_mag_reg) : res_mag_reg;
        fin_s    = fin_mag;
        out_free = !out_valid_reg || out_ch.ready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ch.ready && state_reg != S_FIN)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_ch.valid)
                    begin
                        op_reg      <= in_ch.op;
                        a_raw_reg   <= a_low;
                        b_raw_reg   <= b_low;
                        amag_reg    <= a_mag;
                        bmag_reg    <= b_mag;
                        acc_reg     <= '0;
                        cnt_reg     <= CW'(W - 1);
                        res_neg_reg <= 1'b0;
                        res_mag_reg <= '0;
                        res_st_reg  <= ST_OK;
                        neg_reg     <= a_low[W-1] ^ b_low[W-1];
                        case (in_ch.op)
                            OP_ADD, OP_SUB:
                            begin
                                state_reg <= S_ADD;
                            end
                            OP_MUL:
                            begin
                                mcand_reg  <= a_mag;
                                mplier_reg <= b_mag;
                                state_reg  <= S_MUL;
                            end
                            OP_DIV:
                            begin
                                mplier_reg <= a_mag;
                                if (b_mag == '0)
                                begin
                                    res_st_reg <= ST_DIV0;
                                    state_reg  <= S_FIN;
                                end
                                else
                                begin
                                    state_reg <= S_DIV;
                                end
                            end
                            OP_POW:
                            begin
                                neg_reg     <= a_low[W-1] & b_low[0];
                                m_reg       <= {{(W-1){1'b0}}, 1'b1};
                                idx_reg     <= IW'(EBW - 1);
                                pow_mul_reg <= 1'b0;
                                state_reg   <= S_FIN;
                                if (b_low[W-1])
                                begin
                                    res_st_reg <= ST_NEGEXP;
                                end
                                else if (b_mag == '0)
                                begin
                                    res_mag_reg <= {{(W-1){1'b0}}, 1'b1};
                                end
                                else if (a_mag <= {{(W-1){1'b0}}, 1'b1})
                                begin
                                    res_mag_reg <= a_mag;
                                    res_neg_reg <= a_low[W-1] & b_low[0];
                                end
                                else if (b_mag > W'(W - 1))
                                begin
                                    res_st_reg <= ST_OVF;
                                end
                                else
                                begin
                                    state_reg <= S_POW;
                                end
                            end
                            default:
                            begin
                                state_reg <= S_FIN;
                            end
                        endcase
                    end
                end
                S_ADD:
                begin
                    if (alu_sum[L-1:W-1] != {3{alu_sum[W-1]}})
                    begin
                        res_st_reg <= ST_OVF;
                    end
                    else
                    begin
                        res_mag_reg <= alu_sum[W-1:0];
                    end
                    state_reg <= S_FIN;
                end
                S_POW:
                begin
                    mcand_reg  <= m_reg;
                    mplier_reg <= pow_mul_reg ? amag_reg : m_reg;
                    acc_reg    <= '0;
                    cnt_reg    <= CW'(W - 1);
                    state_reg  <= S_MUL;
                end
                S_MUL:
                begin
                    acc_reg    <= alu_sum[W:0];
                    mplier_reg <= {mplier_reg[W-2:0], 1'b0};
                    cnt_reg    <= cnt_reg - 1'b1;
                    if (alu_sum > lim)
                    begin
                        res_st_reg <= ST_OVF;
                        state_reg  <= S_FIN;
                    end
                    else if (cnt_reg == '0)
                    begin
                        m_reg <= alu_sum[W-1:0];
                        if (op_reg == OP_MUL)
                        begin
                            res_mag_reg <= alu_sum[W-1:0];
                            res_neg_reg <= neg_reg;
                            state_reg   <= S_FIN;
                        end
                        else if (!pow_mul_reg && ebits[idx_reg])
                        begin
                            pow_mul_reg <= 1'b1;
                            state_reg   <= S_POW;
                        end
                        else if (idx_reg == '0)
                        begin
                            res_mag_reg <= alu_sum[W-1:0];
                            res_neg_reg <= neg_reg;
                            state_reg   <= S_FIN;
                        end
                        else
                        begin
                            idx_reg     <= idx_reg - 1'b1;
                            pow_mul_reg <= 1'b0;
                            state_reg   <= S_POW;
                        end
                    end
                end
                S_DIV:
                begin
                    acc_reg    <= qbit ? alu_sum[W:0] : {acc_reg[W-1:0], mplier_reg[W-1]};
                    mplier_reg <= q_new;
                    cnt_reg    <= cnt_reg - 1'b1;
                    if (cnt_reg == '0)
                    begin
                        if ({2'b00, q_new} > lim)
                        begin
                            res_st_reg <= ST_OVF;
                        end
                        else
                        begin
                            res_mag_reg <= q_new;
                            res_neg_reg <= neg_reg;
                        end
                        state_reg <= S_FIN;
                    end
                end
                S_FIN:
                begin
                    if (out_free)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_status_reg <= res_st_reg;
                        out_value_reg  <= (res_st_reg == ST_OK) ? PORT_W'(fin_s) : '0;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_ch.ready   = (state_reg == S_IDLE);
    assign out_ch.valid  = out_valid_reg;
    assign out_ch.value  = out_value_reg;
    assign out_ch.status = out_status_reg;

    `CSAU_ASSERT_NEXT(a_fin_loads_out, state_reg == S_FIN && out_free, out_valid_reg, "result dropped")
    `CSAU_ASSERT_IMPL(a_err_zero, out_valid_reg && out_status_reg != ST_OK, out_value_reg == '0, "error with nonzero value")
    `CSAU_ASSERT_IMPL(a_mul_op, state_reg == S_MUL, op_reg == OP_MUL || op_reg == OP_POW, "multiply for wrong op")
    `CSAU_ASSERT_IMPL(a_div_nonzero, state_reg == S_DIV, bmag_reg != '0, "divide by zero divisor")
endmodule
